[sv/ctc_pkg.sv]
// types and constants shared by the columnar transposition cipher unit
// no dependencies; used by ctc_seq and columnar_transposition_cipher_unit
`default_nettype none

package ctc_pkg;

	// one input item and one result item
	typedef struct packed {
		logic [7:0] char_in;
		logic       last_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last_out;
		logic [1:0] status;
	} result_t;

	// one readout slot from the address sequencer
	typedef struct packed {
		logic issue;
		logic emit;
		logic pad;
		logic tail;
	} seq_slot_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SIZE,
		S_CHECK,
		S_SCAN,
		S_EMIT
	} state_t;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY  = 2'd2;

	localparam int COLS_W = 5;
	localparam int KEY_W  = 64;
	localparam int MAX_COLUMNS = 16;

	localparam logic              MODE_ENCRYPT = 1'b0;
	localparam logic [COLS_W-1:0] COLS_RESET   = 5'd2;
	localparam logic [KEY_W-1:0]  KEY_RESET    = 64'hFEDC_BA98_7654_3210;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_EMPTY    = 2'd2;

	localparam logic [7:0] PAD_CHAR    = 8'h58;
	localparam logic [7:0] SPACE_CHAR  = 8'h20;
	localparam logic [7:0] LOWER_A     = 8'h61;
	localparam logic [7:0] LOWER_Z     = 8'h7a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

endpackage

`default_nettype wire

[sv/ctc_ram.sv]
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module ctc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[sv/ctc_seq.sv]
// readout address sequencer: walks the grid in key order, one slot a cycle
// depends on ctc_pkg
`default_nettype none

module ctc_seq #(
	parameter int MAX_CELLS = 64,
	localparam int AW = $clog2(MAX_CELLS),
	localparam int RW = $clog2(MAX_CELLS + 1),
	localparam int PW = $clog2(MAX_CELLS + ctc_pkg::MAX_COLUMNS)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic                         decrypt,
	input  wire logic [ctc_pkg::COLS_W-1:0]   cols,
	input  wire logic [RW-1:0]                rows,
	input  wire logic [RW-1:0]                len,
	input  wire logic [ctc_pkg::KEY_W-1:0]    key,
	output ctc_pkg::seq_slot_t                slot,
	output logic      [AW-1:0]                addr,
	output logic      [RW-1:0]                idx
);

	logic                       run_q;
	logic [ctc_pkg::COLS_W-1:0] r_q;
	logic [RW-1:0]              j_q;
	logic [PW-1:0]              pos_q;
	logic [RW-1:0]              idx_q;

	logic          found;
	logic [3:0]    sel;
	logic [3:0]    rk;
	logic [RW+3:0] prod;
	logic [RW+3:0] dpos;
	logic          dpad;
	logic [PW-1:0] epos;
	logic          epad;
	logic          row_end;
	logic          col_end;
	logic          emit;
	logic          tail;

	// encrypt: highest-numbered column holding rank r_q
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int c = 0; c < ctc_pkg::MAX_COLUMNS; c++) begin
			if (ctc_pkg::COLS_W'(c) < cols && {1'b0, key[c*4 +: 4]} == r_q) begin
				found = 1'b1;
				sel   = 4'(c);
			end
		end
	end

	assign epos = (j_q == '0) ? PW'(sel) : pos_q;
	assign epad = epos >= PW'(len);

	// decrypt: cell of column r_q in row j_q sits in chunk rank(r_q)
	assign rk   = key[{r_q[3:0], 2'b00} +: 4];
	assign prod = (RW+4)'(rk) * (RW+4)'(rows);
	assign dpos = prod + (RW+4)'(j_q);
	assign dpad = ({1'b0, rk} >= cols) || (dpos >= (RW+4)'(len));

	assign row_end = j_q == rows - RW'(1);
	assign col_end = r_q == cols - ctc_pkg::COLS_W'(1);
	assign emit    = run_q && (decrypt || found);
	assign tail    = run_q && col_end && (decrypt ? row_end : (!found || row_end));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			r_q   <= '0;
			j_q   <= '0;
			idx_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			r_q   <= '0;
			j_q   <= '0;
			idx_q <= '0;
		end else if (run_q) begin
			if (tail) begin
				run_q <= 1'b0;
			end
			if (emit) begin
				idx_q <= idx_q + RW'(1);
			end
			if (decrypt) begin
				if (col_end) begin
					r_q <= '0;
					j_q <= j_q + RW'(1);
				end else begin
					r_q <= r_q + ctc_pkg::COLS_W'(1);
				end
			end else begin
				if (!found || row_end) begin
					j_q <= '0;
					r_q <= r_q + ctc_pkg::COLS_W'(1);
				end else begin
					j_q <= j_q + RW'(1);
				end
			end
		end
	end

	// running address down a column in encrypt mode
	always_ff @(posedge clk) begin
		pos_q <= epos + PW'(cols);
	end

	assign slot.issue = run_q;
	assign slot.emit  = emit;
	assign slot.pad   = decrypt ? dpad : epad;
	assign slot.tail  = tail;
	assign addr       = decrypt ? dpos[AW-1:0] : epos[AW-1:0];
	assign idx        = idx_q;

endmodule

`default_nettype wire

[sv/columnar_transposition_cipher_unit.sv]
// cipher unit top: message store in ctc_ram, readout order from ctc_seq, types from ctc_pkg
// after the last item the unit sizes the grid, checks it, then runs a scan pass over the grid
// in key order and, if it finds an item, an emit pass; a status result comes out of the check
// or the scan pass; one item a cycle while loading, up to one result a cycle while emitting,
// set by the single store read port; the receiver cannot stall; reset clears control and config
`default_nettype none

module columnar_transposition_cipher_unit #(
	parameter int MAX_CELLS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire ctc_pkg::in_item_t               msg,
	output logic                                 strobe,
	output ctc_pkg::result_t                     res,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ctc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ctc_pkg::KEY_W-1:0]       cfg_data
);

	localparam int AW = $clog2(MAX_CELLS);
	localparam int RW = $clog2(MAX_CELLS + 1);
	localparam int PW = $clog2(MAX_CELLS + ctc_pkg::MAX_COLUMNS);

	ctc_pkg::state_t state_q, state_d;

	// configuration
	logic                       mode_q;
	logic [ctc_pkg::COLS_W-1:0] cols_cfg_q;
	logic [ctc_pkg::KEY_W-1:0]  key_q;

	// load side
	logic          accept;
	logic [RW-1:0] count_q, count_next;
	logic          ovf_q, ovf_next;
	logic          keep, room;
	logic [7:0]    ch_conv;
	logic          ram_we;

	// latched per message
	logic                       dec_q;
	logic [ctc_pkg::COLS_W-1:0] cols_q, cols_cl;
	logic [RW-1:0]              len_q;
	logic                       lat_ovf_q;
	logic [RW-1:0]              rows_q;
	logic [PW-1:0]              rc_q;

	// readout
	ctc_pkg::seq_slot_t seq_slot, slot_s1;
	logic [AW-1:0]      seq_addr;
	logic [RW-1:0]      seq_idx, idx_s1;
	logic [7:0]         rd_data;
	logic               seq_start;
	logic               any_q, any_next, hit, pass_done;
	logic [RW-1:0]      last_idx_q;
	logic [7:0]         ch_s1;
	logic               size_bad;

	ctc_pkg::result_t res_d;
	logic             strobe_d;

	assign busy      = state_q != ctc_pkg::S_IDLE;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// encrypt drops spaces and uppercases letters on the way in
	always_comb begin
		keep    = 1'b1;
		ch_conv = msg.char_in;
		if (mode_q == ctc_pkg::MODE_ENCRYPT) begin
			if (msg.char_in == ctc_pkg::SPACE_CHAR) begin
				keep = 1'b0;
			end else if (msg.char_in inside {[ctc_pkg::LOWER_A:ctc_pkg::LOWER_Z]}) begin
				ch_conv = msg.char_in - ctc_pkg::CASE_OFFSET;
			end
		end
	end

	assign room       = count_q < RW'(MAX_CELLS);
	assign ram_we     = accept && keep && room;
	assign count_next = count_q + RW'(keep && room);
	assign ovf_next   = ovf_q || (keep && !room);

	always_comb begin
		if (cols_cfg_q == '0) begin
			cols_cl = ctc_pkg::COLS_W'(1);
		end else if (cols_cfg_q > ctc_pkg::COLS_W'(ctc_pkg::MAX_COLUMNS)) begin
			cols_cl = ctc_pkg::COLS_W'(ctc_pkg::MAX_COLUMNS);
		end else begin
			cols_cl = cols_cfg_q;
		end
	end

	ctc_ram #(
		.WIDTH(8),
		.DEPTH(MAX_CELLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(ch_conv),
		.raddr(seq_addr),
		.rdata(rd_data)
	);

	ctc_seq #(
		.MAX_CELLS(MAX_CELLS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seq_start),
		.decrypt(dec_q),
		.cols   (cols_q),
		.rows   (rows_q),
		.len    (len_q),
		.key    (key_q),
		.slot   (seq_slot),
		.addr   (seq_addr),
		.idx    (seq_idx)
	);

	// stage 1: store data lines up with the slot
	assign ch_s1     = slot_s1.pad ? ctc_pkg::PAD_CHAR : rd_data;
	assign hit       = slot_s1.issue && slot_s1.emit &&
		(!dec_q || (!slot_s1.pad && rd_data != ctc_pkg::PAD_CHAR));
	assign pass_done = slot_s1.issue && slot_s1.tail;
	assign any_next  = any_q || hit;
	assign size_bad  = lat_ovf_q || (rc_q > PW'(MAX_CELLS));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ctc_pkg::S_IDLE: begin
				if (accept && msg.last_in) begin
					state_d = ctc_pkg::S_SIZE;
				end
			end
			ctc_pkg::S_SIZE: begin
				if (rc_q >= PW'(len_q)) begin
					state_d = ctc_pkg::S_CHECK;
				end
			end
			ctc_pkg::S_CHECK: begin
				if (size_bad || len_q == '0) begin
					state_d = ctc_pkg::S_IDLE;
				end else begin
					state_d = ctc_pkg::S_SCAN;
				end
			end
			ctc_pkg::S_SCAN: begin
				if (pass_done) begin
					state_d = any_next ? ctc_pkg::S_EMIT : ctc_pkg::S_IDLE;
				end
			end
			ctc_pkg::S_EMIT: begin
				if (pass_done) begin
					state_d = ctc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ctc_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		seq_start    = 1'b0;
		strobe_d     = 1'b0;
		res_d        = '0;
		res_d.status = ctc_pkg::STATUS_OK;
		case (state_q)
			ctc_pkg::S_CHECK: begin
				if (size_bad) begin
					strobe_d       = 1'b1;
					res_d.last_out = 1'b1;
					res_d.status   = ctc_pkg::STATUS_OVERFLOW;
				end else if (len_q == '0) begin
					strobe_d       = 1'b1;
					res_d.last_out = 1'b1;
					res_d.status   = ctc_pkg::STATUS_EMPTY;
				end else begin
					seq_start = 1'b1;
				end
			end
			ctc_pkg::S_SCAN: begin
				if (pass_done) begin
					if (any_next) begin
						seq_start = 1'b1;
					end else begin
						strobe_d       = 1'b1;
						res_d.last_out = 1'b1;
						res_d.status   = ctc_pkg::STATUS_EMPTY;
					end
				end
			end
			ctc_pkg::S_EMIT: begin
				// trailing pads past the last kept item are dropped
				if (slot_s1.issue && slot_s1.emit && idx_s1 <= last_idx_q) begin
					strobe_d       = 1'b1;
					res_d.char_out = ch_s1;
					res_d.last_out = idx_s1 == last_idx_q;
				end
			end
			default: begin
				seq_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ctc_pkg::S_IDLE;
			mode_q     <= ctc_pkg::MODE_ENCRYPT;
			cols_cfg_q <= ctc_pkg::COLS_RESET;
			key_q      <= ctc_pkg::KEY_RESET;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			slot_s1    <= '0;
			any_q      <= 1'b0;
			strobe     <= 1'b0;
		end else begin
			state_q <= state_d;
			slot_s1 <= seq_slot;
			strobe  <= strobe_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ctc_pkg::CFG_MODE: mode_q     <= cfg_data[0];
					ctc_pkg::CFG_COLS: cols_cfg_q <= cfg_data[ctc_pkg::COLS_W-1:0];
					ctc_pkg::CFG_KEY:  key_q      <= cfg_data;
					default: begin
						mode_q <= mode_q;
					end
				endcase
			end
			if (accept) begin
				if (msg.last_in) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					count_q <= count_next;
					ovf_q   <= ovf_next;
				end
			end
			if (state_q == ctc_pkg::S_CHECK) begin
				any_q <= 1'b0;
			end else if (state_q == ctc_pkg::S_SCAN && hit) begin
				any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= seq_idx;
		res    <= res_d;
		if (accept && msg.last_in) begin
			len_q     <= count_next;
			lat_ovf_q <= ovf_next;
			dec_q     <= mode_q != ctc_pkg::MODE_ENCRYPT;
			cols_q    <= cols_cl;
			rows_q    <= '0;
			rc_q      <= '0;
		end else if (state_q == ctc_pkg::S_SIZE && rc_q < PW'(len_q)) begin
			// rows = ceil(len / cols) by repeated addition
			rows_q <= rows_q + RW'(1);
			rc_q   <= rc_q + PW'(cols_q);
		end
		if (state_q == ctc_pkg::S_SCAN && hit) begin
			last_idx_q <= idx_s1;
		end
	end

	a_strobe_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result strobe without readout activity");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && res.last_out |=> !strobe)
		else $error("result right after the final result of a message");

	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && res.status != ctc_pkg::STATUS_OK |-> res.last_out && res.char_out == 8'h00)
		else $error("status result must be a lone final result with zero char");

	a_no_read_while_load: assert property (@(posedge clk) disable iff (!arst_n)
		seq_slot.issue |-> busy && !ram_we)
		else $error("store read while loading");

	a_pass_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		pass_done |-> state_q == ctc_pkg::S_SCAN || state_q == ctc_pkg::S_EMIT)
		else $error("sequencer pass ended outside readout");

endmodule

`default_nettype wire

[tb/tb_columnar_transposition_cipher_unit.sv]
// self-checking testbench for columnar_transposition_cipher_unit: directed and random messages,
// results checked in order against a predictor of the loaded grid and its key-ordered readout
// depends on ctc_pkg and the unit itself
module tb_columnar_transposition_cipher_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 64;
	localparam int RANDOM_ITEMS = 220;
	localparam int DRAIN_CYCLES = 200;
	localparam int TIMEOUT_NS = 2_000_000;
	localparam logic MODE_DECRYPT = 1'b1;
	localparam logic [7:0] UPPER_A = 8'h41;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	ctc_pkg::in_item_t msg = '0;
	logic strobe;
	ctc_pkg::result_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ctc_pkg::CFG_IDX_W-1:0] cfg_index = ctc_pkg::CFG_MODE;
	logic [ctc_pkg::KEY_W-1:0] cfg_data = '0;

	// predictor copy of the registers and the message store
	logic mode_reg = ctc_pkg::MODE_ENCRYPT;
	logic [ctc_pkg::COLS_W-1:0] cols_reg = ctc_pkg::COLS_RESET;
	logic [ctc_pkg::KEY_W-1:0] key_reg = ctc_pkg::KEY_RESET;
	logic [7:0] loaded [STORE_DEPTH];
	int load_count = 0;
	bit load_overflow = 1'b0;

	ctc_pkg::result_t expected_res [$];
	int errors = 0;
	bit burst = 1'b0;

	columnar_transposition_cipher_unit #(
		.MAX_CELLS(STORE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.msg(msg),
		.strobe(strobe),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [7:0] cell_at(int pos, int len);
		return (pos < len) ? loaded[pos] : ctc_pkg::PAD_CHAR;
	endfunction

	function automatic void push_result(logic [7:0] ch, logic last, logic [1:0] code);
		ctc_pkg::result_t r;
		r.char_out = ch;
		r.last_out = last;
		r.status = code;
		expected_res = {expected_res, r};
	endfunction

	// load one item into the shadow store; on the last item queue the whole readout
	function automatic void load_and_predict(ctc_pkg::in_item_t it);
		logic [7:0] ch;
		logic [7:0] chars [STORE_DEPTH];
		logic [1:0] code;
		bit keep, found;
		int cols, rows, len, sel, rk, n;
		bit ovf;
		ch = it.char_in;
		keep = 1'b1;
		n = 0;
		if (mode_reg == ctc_pkg::MODE_ENCRYPT) begin
			if (ch == ctc_pkg::SPACE_CHAR)
				keep = 1'b0;
			else if (ch >= ctc_pkg::LOWER_A && ch <= ctc_pkg::LOWER_Z)
				ch = ch - ctc_pkg::CASE_OFFSET;
		end
		if (keep) begin
			if (load_count < STORE_DEPTH) begin
				loaded[load_count] = ch;
				load_count++;
			end else begin
				load_overflow = 1'b1;
			end
		end
		if (!it.last_in)
			return;

		len = load_count;
		ovf = load_overflow;
		load_count = 0;
		load_overflow = 1'b0;
		cols = int'(cols_reg);
		if (cols == 0)
			cols = 1;
		if (cols > ctc_pkg::MAX_COLUMNS)
			cols = ctc_pkg::MAX_COLUMNS;
		rows = (len + cols - 1) / cols;

		code = ctc_pkg::STATUS_OK;
		if (ovf || rows * cols > STORE_DEPTH) begin
			code = ctc_pkg::STATUS_OVERFLOW;
		end else if (len == 0) begin
			code = ctc_pkg::STATUS_EMPTY;
		end else begin
			if (mode_reg == ctc_pkg::MODE_ENCRYPT) begin
				// highest column holding a rank wins, unheld ranks emit nothing
				for (int r = 0; r < cols; r++) begin
					found = 1'b0;
					sel = 0;
					for (int c = 0; c < cols; c++) begin
						if (int'(key_reg[c*4 +: 4]) == r) begin
							found = 1'b1;
							sel = c;
						end
					end
					if (found) begin
						for (int j = 0; j < rows && n < STORE_DEPTH; j++) begin
							chars[n] = cell_at(j * cols + sel, len);
							n++;
						end
					end
				end
			end else begin
				for (int j = 0; j < rows; j++) begin
					for (int c = 0; c < cols && n < STORE_DEPTH; c++) begin
						rk = int'(key_reg[c*4 +: 4]);
						chars[n] = (rk < cols) ? cell_at(rk * rows + j, len) : ctc_pkg::PAD_CHAR;
						n++;
					end
				end
				while (n > 0 && chars[n-1] == ctc_pkg::PAD_CHAR)
					n--;
			end
			if (n == 0)
				code = ctc_pkg::STATUS_EMPTY;
		end

		if (code != ctc_pkg::STATUS_OK)
			push_result(8'h00, 1'b1, code);
		else
			for (int i = 0; i < n; i++)
				push_result(chars[i], i == n - 1, ctc_pkg::STATUS_OK);
	endfunction

	always @(posedge clk) begin : check_results
		ctc_pkg::result_t want;
		if (arst_n && strobe) begin
			if (expected_res.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: char %h last %b status %0d",
						res.char_out, res.last_out, res.status);
			end else begin
				want = expected_res.pop_front();
				if (res.char_out !== want.char_out || res.last_out !== want.last_out ||
						res.status !== want.status) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: want %h/%b/%0d got %h/%b/%0d",
							want.char_out, want.last_out, want.status,
							res.char_out, res.last_out, res.status);
				end
			end
		end
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] rand_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 8'(UPPER_A + $urandom_range(0, 25));
		if (r < 60)
			return 8'(ctc_pkg::LOWER_A + $urandom_range(0, 25));
		if (r < 72)
			return ctc_pkg::SPACE_CHAR;
		if (r < 80)
			return ctc_pkg::PAD_CHAR;
		return 8'($urandom_range(0, 255));
	endfunction

	// column ranks shuffled over the used columns, unused nibbles left random
	function automatic logic [ctc_pkg::KEY_W-1:0] shuffled_key(int cols);
		int perm [16];
		int j, t;
		logic [ctc_pkg::KEY_W-1:0] k;
		k = {$urandom, $urandom};
		for (int i = 0; i < 16; i++)
			perm[i] = i;
		for (int i = cols - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (int i = 0; i < cols; i++)
			k[i*4 +: 4] = 4'(perm[i]);
		return k;
	endfunction

	task automatic send_item(ctc_pkg::in_item_t it);
		int gap;
		start <= 1'b1;
		msg <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		load_and_predict(it);
		gap = rand_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_byte(logic [7:0] ch, logic last);
		ctc_pkg::in_item_t it;
		it.char_in = ch;
		it.last_in = last;
		send_item(it);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	// stop sending and let the readout run out before touching registers
	task automatic settle();
		start <= 1'b0;
		while (expected_res.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [ctc_pkg::CFG_IDX_W-1:0] idx,
			logic [ctc_pkg::KEY_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			ctc_pkg::CFG_MODE: mode_reg = data[0];
			ctc_pkg::CFG_COLS: cols_reg = data[ctc_pkg::COLS_W-1:0];
			ctc_pkg::CFG_KEY: key_reg = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random message; mode flips before byte flip_at when that is past the first byte
	task automatic send_random_msg(int len, int flip_at);
		for (int i = 0; i < len; i++) begin
			if (i == flip_at && i > 0) begin
				settle();
				write_reg(ctc_pkg::CFG_MODE, {63'd0, ~mode_reg});
			end
			send_byte(rand_char(), i == len - 1);
		end
	endtask

	task automatic reconfigure();
		int cols, r;
		settle();
		write_reg(ctc_pkg::CFG_MODE, 64'($urandom_range(0, 1)));
		r = $urandom_range(0, 9);
		if (r == 0)
			cols = 0;
		else if (r == 1)
			cols = $urandom_range(17, 31);
		else if (r == 2)
			cols = 16;
		else
			cols = $urandom_range(1, 16);
		write_reg(ctc_pkg::CFG_COLS, 64'(cols));
		r = $urandom_range(0, 9);
		if (r == 0)
			write_reg(ctc_pkg::CFG_KEY, '0);
		else if (r == 1)
			write_reg(ctc_pkg::CFG_KEY, {ctc_pkg::KEY_W{1'b1}});
		else if (r == 2)
			write_reg(ctc_pkg::CFG_KEY, {$urandom, $urandom});
		else
			write_reg(ctc_pkg::CFG_KEY,
				shuffled_key((cols == 0) ? 1 : (cols > 16) ? 16 : cols));
	endtask

	task automatic test_directed();
		// reset setting: encrypt, two columns, identity key
		send_text("ab c");
		// a trailing space still ends the message, leaving it empty
		send_text(" ");
		settle();
		write_reg(ctc_pkg::CFG_MODE, {63'd0, MODE_DECRYPT});
		send_text("aB X");
		send_text("XX");
		settle();
		write_reg(ctc_pkg::CFG_COLS, 64'd0);
		write_reg(ctc_pkg::CFG_KEY, '0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);
		settle();
		// every column claims rank 15, so only the last column shows
		write_reg(ctc_pkg::CFG_MODE, {63'd0, ctc_pkg::MODE_ENCRYPT});
		write_reg(ctc_pkg::CFG_COLS, 64'd31);
		write_reg(ctc_pkg::CFG_KEY, {ctc_pkg::KEY_W{1'b1}});
		send_text("Zz");
		settle();
		// no column holds a usable rank
		write_reg(ctc_pkg::CFG_COLS, 64'd2);
		send_text("AB");
		settle();
		write_reg(ctc_pkg::CFG_COLS, 64'd3);
		write_reg(ctc_pkg::CFG_KEY, '0);
		send_text("ABC");
		settle();
		// one rank beyond the column count reads as padding
		write_reg(ctc_pkg::CFG_MODE, {63'd0, MODE_DECRYPT});
		write_reg(ctc_pkg::CFG_COLS, 64'd4);
		write_reg(ctc_pkg::CFG_KEY, 64'h0000_0000_0000_9210);
		send_text("ABCD");
	endtask

	task automatic test_mode_switch();
		settle();
		write_reg(ctc_pkg::CFG_COLS, 64'd2);
		write_reg(ctc_pkg::CFG_KEY, ctc_pkg::KEY_RESET);
		send_byte("a", 1'b0);
		send_byte("b", 1'b0);
		settle();
		write_reg(ctc_pkg::CFG_MODE, {63'd0, ctc_pkg::MODE_ENCRYPT});
		send_text("c d");
		send_byte("x", 1'b0);
		send_byte(ctc_pkg::SPACE_CHAR, 1'b0);
		settle();
		write_reg(ctc_pkg::CFG_MODE, {63'd0, MODE_DECRYPT});
		send_byte("y", 1'b0);
		send_byte(ctc_pkg::SPACE_CHAR, 1'b1);
	endtask

	task automatic test_capacity();
		settle();
		write_reg(ctc_pkg::CFG_MODE, {63'd0, MODE_DECRYPT});
		write_reg(ctc_pkg::CFG_COLS, 64'd13);
		write_reg(ctc_pkg::CFG_KEY, shuffled_key(13));
		// 53 bytes over 13 columns need a 65-cell grid
		send_random_msg(53, -1);
		settle();
		write_reg(ctc_pkg::CFG_COLS, 64'd16);
		write_reg(ctc_pkg::CFG_KEY, shuffled_key(16));
		send_random_msg(STORE_DEPTH, -1);
		send_random_msg(STORE_DEPTH + 2, -1);
	endtask

	task automatic test_random();
		int sent, len, r, flip;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0)
				reconfigure();
			burst = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 19);
			if (r == 0)
				len = $urandom_range(33, STORE_DEPTH);
			else if (r < 5)
				len = $urandom_range(1, 3);
			else
				len = $urandom_range(4, 16);
			flip = -1;
			if ($urandom_range(0, 9) == 0)
				flip = $urandom_range(1, len);
			send_random_msg(len, flip);
			sent += len;
		end
		burst = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_mode_switch();
		test_capacity();
		test_random();
		start <= 1'b0;
		while (expected_res.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
